>>> src/gcec_pkg.sv
`default_nettype none

package gcec_pkg;

    localparam int CELL_W     = 12;
    localparam int GATE_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int HEIGHT_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int OFF_W      = 2;
    localparam int COST_W     = 18;
    localparam int PEN_W      = 10;

    // Square root chain: two radicand bits per cell.
    localparam int ROOT_W     = COST_W;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_CELLS = ROOT_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GATE = 8'd1;

    localparam logic [CELL_W-1:0] CELL_SIZE_RESET   = 12'd250;
    localparam logic [GATE_W-1:0] HEIGHT_GATE_RESET = 16'd0;
    localparam logic [GATE_W-1:0] DEFAULT_GATE      = 16'd350;

    localparam logic [PEN_W-1:0] PEN_LE1  = 10'd1000;
    localparam logic [PEN_W-1:0] PEN_LE2  = 10'd600;
    localparam logic [PEN_W-1:0] PEN_LE4  = 10'd300;
    localparam logic [PEN_W-1:0] PEN_NONE = 10'd0;

    // Intensity term: floor(625 * dint^2 / (2048 * 2601)).
    localparam logic [41:0] INT_SCALE = 42'd625;
    localparam logic [31:0] INT_DIV   = 32'd2601;
    localparam logic [20:0] INT_RECIP = 21'd1651275;

    typedef struct packed {
        logic [HEIGHT_W-1:0] a_mean_height;
        logic [HEIGHT_W-1:0] a_max_height;
        logic [HEIGHT_W-1:0] a_mean_intensity;
        logic [COUNT_W-1:0]  a_point_count;
        logic [HEIGHT_W-1:0] b_mean_height;
        logic [HEIGHT_W-1:0] b_max_height;
        logic [HEIGHT_W-1:0] b_mean_intensity;
        logic [COUNT_W-1:0]  b_point_count;
        logic [OFF_W-1:0]    row_offset;
        logic [OFF_W-1:0]    col_offset;
    } gcec_item_t;

    typedef struct packed {
        logic [PEN_W-1:0] penalty;
        logic             gated;
    } gcec_side_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        gcec_side_t        side;
    } gcec_root_t;

endpackage

`default_nettype wire

>>> src/gcec_if.sv
`default_nettype none

interface gcec_cfg_if import gcec_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface gcec_item_if import gcec_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] a_mean_height;
    logic signed [HEIGHT_W-1:0] a_max_height;
    logic [HEIGHT_W-1:0]        a_mean_intensity;
    logic [COUNT_W-1:0]         a_point_count;
    logic signed [HEIGHT_W-1:0] b_mean_height;
    logic signed [HEIGHT_W-1:0] b_max_height;
    logic [HEIGHT_W-1:0]        b_mean_intensity;
    logic [COUNT_W-1:0]         b_point_count;
    logic signed [OFF_W-1:0]    row_offset;
    logic signed [OFF_W-1:0]    col_offset;

    modport source (
        output valid, output a_mean_height, output a_max_height,
        output a_mean_intensity, output a_point_count, output b_mean_height,
        output b_max_height, output b_mean_intensity, output b_point_count,
        output row_offset, output col_offset, input ready
    );
    modport sink (
        input valid, input a_mean_height, input a_max_height,
        input a_mean_intensity, input a_point_count, input b_mean_height,
        input b_max_height, input b_mean_intensity, input b_point_count,
        input row_offset, input col_offset, output ready
    );
endinterface

interface gcec_result_if import gcec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] edge_cost_mm;
    logic              gated;

    modport source (output valid, output edge_cost_mm, output gated, input ready);
    modport sink (input valid, input edge_cost_mm, input gated, output ready);
endinterface

`default_nettype wire

>>> src/gcec_front.sv
`default_nettype none

module gcec_front
    import gcec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire gcec_item_t        item,
    input  wire logic [CELL_W-1:0] cell_size,
    input  wire logic [GATE_W-1:0] height_gate,
    output logic                   out_valid,
    output gcec_root_t             out_work
);

    function automatic logic [15:0] mag17(input logic [16:0] d);
        logic [16:0] n;
        begin
            n = 17'd0 - d;
            return d[16] ? n[15:0] : d[15:0];
        end
    endfunction

    function automatic logic [CELL_W+1:0] off_dist(input logic [OFF_W-1:0] off,
                                                   input logic [CELL_W-1:0] cs);
        logic [CELL_W+1:0] d;
        begin
            case (off)
                2'b00:   d = '0;
                2'b10:   d = {1'b0, cs, 1'b0};
                default: d = {2'b00, cs};
            endcase
            return d;
        end
    endfunction

    // Stage 1: differences, gate test, sparsity penalty, spatial offsets.
    logic [16:0]        dmean_raw, dmax_raw, dint_raw;
    logic [15:0]        dmean_next, dmax_next, dint_next;
    logic [CELL_W+1:0]  rd_next, cd_next;
    logic [GATE_W-1:0]  gate_eff;
    logic [COUNT_W-1:0] cnt_min;
    gcec_side_t         side_next;

    always_comb
    begin
        dmean_raw = {item.a_mean_height[15], item.a_mean_height}
                  - {item.b_mean_height[15], item.b_mean_height};
        dmax_raw  = {item.a_max_height[15], item.a_max_height}
                  - {item.b_max_height[15], item.b_max_height};
        dint_raw  = {1'b0, item.a_mean_intensity} - {1'b0, item.b_mean_intensity};
        dmean_next = mag17(dmean_raw);
        dmax_next  = mag17(dmax_raw);
        dint_next  = mag17(dint_raw);
        rd_next = off_dist(item.row_offset, cell_size);
        cd_next = off_dist(item.col_offset, cell_size);
        gate_eff = (height_gate == '0) ? DEFAULT_GATE : height_gate;
        cnt_min = (item.a_point_count < item.b_point_count) ? item.a_point_count
                                                            : item.b_point_count;
        side_next.gated = (dmax_next > gate_eff);
        if (cnt_min <= 16'd1)
            side_next.penalty = PEN_LE1;
        else if (cnt_min == 16'd2)
            side_next.penalty = PEN_LE2;
        else if (cnt_min <= 16'd4)
            side_next.penalty = PEN_LE4;
        else
            side_next.penalty = PEN_NONE;
    end

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    gcec_side_t        side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic [15:0]       dmean_reg, dmax_reg, dint_reg;
    logic [CELL_W+1:0] rd_reg, cd_reg;

    // Stage 2: squares.
    logic [31:0] sq_mean_next, sq_max_next, sq_int_next;
    logic [27:0] sq_rd_next, sq_cd_next;
    logic [31:0] sq_mean_reg, sq_max_reg, sq_int_reg;
    logic [27:0] sq_rd_reg, sq_cd_reg;

    assign sq_mean_next = {16'd0, dmean_reg} * {16'd0, dmean_reg};
    assign sq_max_next  = {16'd0, dmax_reg} * {16'd0, dmax_reg};
    assign sq_int_next  = {16'd0, dint_reg} * {16'd0, dint_reg};
    assign sq_rd_next   = {14'd0, rd_reg} * {14'd0, rd_reg};
    assign sq_cd_next   = {14'd0, cd_reg} * {14'd0, cd_reg};

    // Stage 3: spatial sum, weighted height sum, scaled intensity.
    logic [28:0] sp_next, sp_reg;
    logic [34:0] hsum_next, hsum_reg;
    logic [41:0] int_scaled;
    logic [30:0] y_next, y3_reg;

    assign sp_next    = {1'b0, sq_rd_reg} + {1'b0, sq_cd_reg};
    assign hsum_next  = {2'b00, sq_mean_reg, 1'b0} + {2'b00, sq_max_reg, 1'b0}
                      + {3'b000, sq_max_reg};
    assign int_scaled = {10'd0, sq_int_reg} * INT_SCALE;
    assign y_next     = int_scaled[41:11];

    // Stage 4: height and spatial total, reciprocal estimate of y / 2601.
    logic [34:0] acc_next, acc4_reg, acc5_reg;
    logic [51:0] qprod;
    logic [19:0] q0_next, q0_reg, q5_reg;
    logic [30:0] y4_reg;

    assign acc_next = {6'd0, sp_reg} + hsum_reg;
    assign qprod    = {21'd0, y3_reg} * {31'd0, INT_RECIP};
    assign q0_next  = qprod[51:32];

    // Stage 5: remainder of the estimate; it stays below twice the divisor.
    logic [31:0] back, rdiff;
    logic [12:0] r_next, r_reg;

    assign back   = {12'd0, q0_reg} * INT_DIV;
    assign rdiff  = {1'b0, y4_reg} - back;
    assign r_next = rdiff[12:0];

    // Stage 6: corrected quotient added to the total.
    logic [19:0]      q_fix;
    logic [RAD_W-1:0] rad_next, rad_reg;

    assign q_fix    = q5_reg + {19'd0, (r_reg >= INT_DIV[12:0])};
    assign rad_next = {1'b0, acc5_reg} + {16'd0, q_fix};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmean_reg <= dmean_next;
            dmax_reg  <= dmax_next;
            dint_reg  <= dint_next;
            rd_reg    <= rd_next;
            cd_reg    <= cd_next;
            side1_reg <= side_next;

            sq_mean_reg <= sq_mean_next;
            sq_max_reg  <= sq_max_next;
            sq_int_reg  <= sq_int_next;
            sq_rd_reg   <= sq_rd_next;
            sq_cd_reg   <= sq_cd_next;
            side2_reg   <= side1_reg;

            sp_reg    <= sp_next;
            hsum_reg  <= hsum_next;
            y3_reg    <= y_next;
            side3_reg <= side2_reg;

            acc4_reg  <= acc_next;
            q0_reg    <= q0_next;
            y4_reg    <= y3_reg;
            side4_reg <= side3_reg;

            acc5_reg  <= acc4_reg;
            q5_reg    <= q0_reg;
            r_reg     <= r_next;
            side5_reg <= side4_reg;

            rad_reg   <= rad_next;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid     = v6_reg;
    assign out_work.rad  = rad_reg;
    assign out_work.rem  = '0;
    assign out_work.root = '0;
    assign out_work.side = side6_reg;

endmodule

`default_nettype wire

>>> src/gcec_sqrt_cell.sv
`default_nettype none

module gcec_sqrt_cell
    import gcec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       in_valid,
    input  wire gcec_root_t in_work,
    output logic            out_valid,
    output gcec_root_t      out_work
);

    // One digit of the restoring square root: bring down two radicand bits,
    // try (root << 2) | 1 against the partial remainder.
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rem_sub;
    logic             take;
    gcec_root_t       work_next;
    gcec_root_t       work_reg;
    logic             valid_reg;

    always_comb
    begin
        rem_sh  = {in_work.rem, in_work.rad[RAD_W-1 -: 2]};
        trial   = {2'b00, in_work.root, 2'b01};
        rem_sub = rem_sh - trial;
        take    = (rem_sh >= trial);
        work_next.rad  = {in_work.rad[RAD_W-3:0], 2'b00};
        work_next.rem  = take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        work_next.root = {in_work.root[ROOT_W-2:0], take};
        work_next.side = in_work.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

>>> src/grid_cell_edge_cost.sv
`default_nettype none

// Edge weight between two neighboring grid cells. One word is taken per
// clock and one result word leaves per clock unless the output stalls; an
// item passes through six arithmetic stages, a chain of 18 square-root
// cells resolving one root bit each, and the output register. The whole
// pipeline advances together whenever the output register is empty or
// being read, so input ready follows output ready in the same cycle.
// Configuration writes are always accepted and take effect on the next
// item; write them only when no item is in flight.

module grid_cell_edge_cost
    import gcec_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gcec_cfg_if.sink    cfg,
    gcec_item_if.sink   item_in,
    gcec_result_if.source item_out
);

    logic [CELL_W-1:0] cell_size_reg;
    logic [GATE_W-1:0] height_gate_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg   <= CELL_SIZE_RESET;
            height_gate_reg <= HEIGHT_GATE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CELL_SIZE:   cell_size_reg   <= cfg.data[CELL_W-1:0];
                CFG_HEIGHT_GATE: height_gate_reg <= cfg.data[GATE_W-1:0];
                default:         ;
            endcase
        end
    end

    logic       out_valid_reg;
    logic       adv;
    gcec_item_t item;

    assign adv           = !out_valid_reg || item_out.ready;
    assign item_in.ready = adv;

    assign item.a_mean_height    = item_in.a_mean_height;
    assign item.a_max_height     = item_in.a_max_height;
    assign item.a_mean_intensity = item_in.a_mean_intensity;
    assign item.a_point_count    = item_in.a_point_count;
    assign item.b_mean_height    = item_in.b_mean_height;
    assign item.b_max_height     = item_in.b_max_height;
    assign item.b_mean_intensity = item_in.b_mean_intensity;
    assign item.b_point_count    = item_in.b_point_count;
    assign item.row_offset       = item_in.row_offset;
    assign item.col_offset       = item_in.col_offset;

    logic       chain_valid [SQRT_CELLS+1];
    gcec_root_t chain_work  [SQRT_CELLS+1];

    gcec_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (item_in.valid),
        .item        (item),
        .cell_size   (cell_size_reg),
        .height_gate (height_gate_reg),
        .out_valid   (chain_valid[0]),
        .out_work    (chain_work[0])
    );

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_cell
        gcec_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    gcec_root_t        last;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] cost_next;
    logic [COST_W-1:0] cost_reg;
    logic              gated_reg;

    assign last      = chain_work[SQRT_CELLS];
    assign cost_sum  = {1'b0, last.root} + {{(COST_W+1-PEN_W){1'b0}}, last.side.penalty};
    assign cost_next = (last.side.gated || cost_sum[COST_W]) ? '1 : cost_sum[COST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= chain_valid[SQRT_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cost_reg  <= cost_next;
            gated_reg <= last.side.gated;
        end
    end

    assign item_out.valid        = out_valid_reg;
    assign item_out.edge_cost_mm = cost_reg;
    assign item_out.gated        = gated_reg;

`ifndef ASSERT_OFF
    a_gated_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && gated_reg) |-> (cost_reg == '1))
        else $error("gated edge without saturated cost");

    a_chain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[SQRT_CELLS] && adv) |=> out_valid_reg)
        else $error("finished root lost before the output register");

    a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[SQRT_CELLS] |->
            ({1'b0, last.rem} <= {2'b00, last.root, 1'b0}))
        else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

>>> tb/grid_cell_edge_cost_test.sv
`timescale 1ns / 1ps

module grid_cell_edge_cost_test;
    import gcec_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX = 50;
    localparam longint unsigned INT_GAIN = 500000;
    localparam longint unsigned INT_FULL = 65280;
    localparam longint unsigned COST_CEIL = (64'd1 << COST_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'hA5;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic              gated;
    } edge_t;

    logic clk;
    logic rst_n;

    gcec_cfg_if    cfg_bus ();
    gcec_item_if   item_bus ();
    gcec_result_if result_bus ();

    grid_cell_edge_cost uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .item_in  (item_bus),
        .item_out (result_bus)
    );

    gcec_item_t pending[$];
    edge_t      costs_due[$];
    gcec_item_t on_bus;
    edge_t      want;

    logic [CELL_W-1:0] cell_mm_now;
    logic [GATE_W-1:0] gate_mm_now;

    logic item_taken;
    logic result_taken;
    bit   send_steady;
    bit   take_steady;
    int   send_gap;
    int   hold_left;
    int   cycles;
    int   mismatches;
    int   edges_in;
    int   edges_out;
    int   blocked;
    int   reg_writes;

    // Expected weight of one edge under the given register values.
    function automatic edge_t predict_edge(gcec_item_t it, logic [CELL_W-1:0] cell_mm,
                                           logic [GATE_W-1:0] gate_reg);
        edge_t res;
        longint dmax;
        longint dmean;
        longint dint;
        longint rd;
        longint cd;
        longint unsigned gate_mm;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned fewest;
        gate_mm = (gate_reg != 0) ? gate_reg : DEFAULT_GATE;
        dmax = longint'($signed(it.a_max_height)) - longint'($signed(it.b_max_height));
        if (dmax < 0) dmax = -dmax;
        if (dmax > longint'(gate_mm)) begin
            res.cost = '1;
            res.gated = 1'b1;
        end
        else begin
            rd = longint'($signed(it.row_offset));
            cd = longint'($signed(it.col_offset));
            if (rd < 0) rd = -rd;
            if (cd < 0) cd = -cd;
            rd = rd * longint'(cell_mm);
            cd = cd * longint'(cell_mm);
            dmean = longint'($signed(it.a_mean_height)) - longint'($signed(it.b_mean_height));
            if (dmean < 0) dmean = -dmean;
            dint = longint'(it.a_mean_intensity) - longint'(it.b_mean_intensity);
            if (dint < 0) dint = -dint;
            radicand = rd * rd + cd * cd + 2 * dmean * dmean + 3 * dmax * dmax
                       + (INT_GAIN * dint * dint) / (INT_FULL * INT_FULL);
            // Settle the root one bit at a time from the top.
            root = 0;
            for (int b = 19; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= radicand) root = trial;
            end
            fewest = (it.a_point_count < it.b_point_count) ? it.a_point_count
                                                           : it.b_point_count;
            if (fewest <= 1) root += PEN_LE1;
            else if (fewest == 2) root += PEN_LE2;
            else if (fewest <= 4) root += PEN_LE4;
            if (root > COST_CEIL) root = COST_CEIL;
            res.cost = root[COST_W-1:0];
            res.gated = 1'b0;
        end
        return res;
    endfunction

    function automatic gcec_item_t cell_pair(int am, int ax, int ai, int ac,
                                             int bm, int bx, int bi, int bc,
                                             int ro, int co);
        gcec_item_t it;
        it.a_mean_height = 16'(am);
        it.a_max_height = 16'(ax);
        it.a_mean_intensity = 16'(ai);
        it.a_point_count = 16'(ac);
        it.b_mean_height = 16'(bm);
        it.b_max_height = 16'(bx);
        it.b_mean_intensity = 16'(bi);
        it.b_point_count = 16'(bc);
        it.row_offset = 2'(ro);
        it.col_offset = 2'(co);
        return it;
    endfunction

    // Appends one edge to the tail of the send queue.
    function automatic void queue_edge(gcec_item_t it);
        pending.insert(pending.size(), it);
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Most pairs keep the max heights within reach of the gate so that the
    // cost path is exercised; the rest are fully random and mostly blocked.
    function automatic gcec_item_t random_edge(int gate_eff);
        gcec_item_t it;
        logic [159:0] noise;
        int span;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(gcec_item_t)-1:0];
        if ($urandom_range(0, 9) < 7) begin
            span = gate_eff + 2;
            it.b_max_height = clamp16(int'($signed(it.a_max_height))
                                      + int'($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 1))
                it.b_mean_height = clamp16(int'($signed(it.a_mean_height))
                                           + int'($urandom_range(0, 1000)) - 500);
            if ($urandom_range(0, 1)) begin
                it.a_point_count = 16'($urandom_range(0, 6));
                it.b_point_count = 16'($urandom_range(0, 6));
            end
        end
        return it;
    endfunction

    function automatic int effective_gate();
        return (gate_mm_now != 0) ? int'(gate_mm_now) : int'(DEFAULT_GATE);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0 || item_bus.valid || costs_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            queue_edge(random_edge(effective_gate()));
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sender: one word per handshake, with a random pause after each one outside steady stretches.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            item_bus.valid <= 1'b0;
        end
        else if (!item_bus.valid || item_taken) begin
            if (send_gap > 0) begin
                item_bus.valid <= 1'b0;
                send_gap--;
            end
            else if (pending.size() > 0) begin
                on_bus = pending.pop_front();
                item_bus.valid <= 1'b1;
                item_bus.a_mean_height <= on_bus.a_mean_height;
                item_bus.a_max_height <= on_bus.a_max_height;
                item_bus.a_mean_intensity <= on_bus.a_mean_intensity;
                item_bus.a_point_count <= on_bus.a_point_count;
                item_bus.b_mean_height <= on_bus.b_mean_height;
                item_bus.b_max_height <= on_bus.b_max_height;
                item_bus.b_mean_intensity <= on_bus.b_mean_intensity;
                item_bus.b_point_count <= on_bus.b_point_count;
                item_bus.row_offset <= on_bus.row_offset;
                item_bus.col_offset <= on_bus.col_offset;
                if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 9);
            end
            else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: after each word taken, hold ready low for a random pause, except in steady stretches.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
        end
        else begin
            if (result_taken) begin
                if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
                hold_left = take_steady ? 0 : $urandom_range(0, 9);
            end
            if (hold_left > 0) begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        item_taken <= item_bus.valid && item_bus.ready;
        result_taken <= result_bus.valid && result_bus.ready;
        if (cfg_bus.valid && cfg_bus.ready) begin
            reg_writes++;
            case (cfg_bus.index)
                CFG_CELL_SIZE:   cell_mm_now <= cfg_bus.data[CELL_W-1:0];
                CFG_HEIGHT_GATE: gate_mm_now <= cfg_bus.data[GATE_W-1:0];
                default:         ;
            endcase
        end
        if (item_bus.valid && item_bus.ready) begin
            costs_due.insert(costs_due.size(), predict_edge(on_bus, cell_mm_now, gate_mm_now));
            edges_in++;
        end
        if (result_bus.valid && result_bus.ready) begin
            if (costs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with none pending: cost %0d gated %0b", $time,
                             result_bus.edge_cost_mm, result_bus.gated);
            end
            else begin
                want = costs_due.pop_front();
                edges_out++;
                if (want.gated) blocked++;
                if (result_bus.edge_cost_mm !== want.cost || result_bus.gated !== want.gated)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: expected cost %0d gated %0b, got cost %0d gated %0b",
                                 $time, want.cost, want.gated,
                                 result_bus.edge_cost_mm, result_bus.gated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        item_bus.valid = 1'b0;
        item_bus.a_mean_height = '0;
        item_bus.a_max_height = '0;
        item_bus.a_mean_intensity = '0;
        item_bus.a_point_count = '0;
        item_bus.b_mean_height = '0;
        item_bus.b_max_height = '0;
        item_bus.b_mean_intensity = '0;
        item_bus.b_point_count = '0;
        item_bus.row_offset = '0;
        item_bus.col_offset = '0;
        result_bus.ready = 1'b0;
        cell_mm_now = CELL_SIZE_RESET;
        gate_mm_now = HEIGHT_GATE_RESET;
        item_taken = 1'b0;
        result_taken = 1'b0;
        send_steady = 1'b0;
        take_steady = 1'b0;
        send_gap = 0;
        hold_left = 0;
        cycles = 0;
        mismatches = 0;
        edges_in = 0;
        edges_out = 0;
        blocked = 0;
        reg_writes = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: default gate of 350 mm and 250 mm cells.
        queue_edge(cell_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_edge(cell_pair(0, 350, 256, 5, 0, 0, 256, 5, 1, 0));
        queue_edge(cell_pair(0, 0, 0, 5, 0, 351, 0, 5, 0, 1));
        queue_edge(cell_pair(0, -32768, 0, 9, 0, -32418, 0, 9, -1, -1));
        queue_edge(cell_pair(100, 10, 0, 1, 0, 0, 0, 1000, 1, 1));
        queue_edge(cell_pair(100, 10, 0, 2, 0, 0, 0, 2, 1, 1));
        queue_edge(cell_pair(100, 10, 0, 3, 0, 0, 0, 77, 1, 1));
        queue_edge(cell_pair(100, 10, 0, 65535, 0, 0, 0, 4, 1, 1));
        queue_edge(cell_pair(100, 10, 0, 5, 0, 0, 0, 5, 1, 1));
        queue_edge(cell_pair(0, 0, 65280, 65535, 0, 0, 0, 65535, 0, 0));
        queue_edge(cell_pair(0, 0, 0, 65535, 0, 0, 65535, 65535, 0, 0));
        queue_edge(cell_pair(32767, 0, 0, 10, -32768, 0, 0, 10, -2, -2));
        queue_edge(cell_pair(-5, 7, 1000, 20, 5, -7, 2000, 20, -1, 1));
        queue_edge(cell_pair(5, -7, 2000, 20, -5, 7, 1000, 20, 1, -1));
        drain();

        // Largest cells and a gate that nothing can exceed.
        write_reg(CFG_CELL_SIZE, 16'h0FFF);
        write_reg(CFG_HEIGHT_GATE, 16'hFFFF);
        queue_edge(cell_pair(32767, 32767, 65535, 65535,
                             -32768, -32768, 0, 65535, -2, -2));
        queue_edge(cell_pair(-32768, -32768, 0, 3, 32767, 32767, 65280, 4, 1, -1));
        send_random(200);

        // Upper data bits are dropped, leaving a cell size of zero.
        write_reg(CFG_CELL_SIZE, 16'hF000);
        write_reg(CFG_HEIGHT_GATE, 16'h0001);
        send_random(200);

        // A write to an unused index must change nothing.
        write_reg(CFG_NO_REG, 16'h1234);
        write_reg(CFG_CELL_SIZE, 16'h0001);
        write_reg(CFG_HEIGHT_GATE, 16'h0000);
        queue_edge(cell_pair(0, 0, 0, 5, 0, 350, 0, 5, 0, 0));
        queue_edge(cell_pair(0, 351, 0, 5, 0, 0, 0, 5, 0, 0));
        queue_edge(cell_pair(0, -351, 0, 5, 0, 0, 0, 5, 1, 1));
        send_random(200);

        for (int phase = 0; phase < 2; phase++) begin
            write_reg(CFG_CELL_SIZE, 16'($urandom_range(1, 4095)));
            write_reg(CFG_HEIGHT_GATE, 16'($urandom_range(0, 2000)));
            send_random(200);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d edges sent, %0d weights checked, %0d blocked by the height gate",
                 edges_in, edges_out, blocked);
        $display("%0d register writes, cell sizes from 0 to 4095 and gates from 0 to 65535",
                 reg_writes);
        if (mismatches == 0 && costs_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
src/gcec_pkg.sv
src/gcec_if.sv
src/gcec_front.sv
src/gcec_sqrt_cell.sv
src/grid_cell_edge_cost.sv
tb/grid_cell_edge_cost_test.sv
